// ===== src/gpm_pkg.sv =====
// Shared types and constants for the gray to pseudocolor mapper.
// Used by the front end, the queue, the divider, the back end and the top level.
package gpm_pkg;

	localparam int GRAY_W = 8;
	localparam int DATA_W = 8;
	localparam int NUM_W = 27;
	localparam int DEN_W = 11;
	localparam int QUO_W = 16;
	localparam int LANES = 3;
	localparam int SPLIT_W = 9;
	localparam int HUE_X_W = 19;

	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_LOW = 3'd1;
	localparam logic [2:0] REG_HIGH = 3'd2;
	localparam logic [2:0] REG_SPLIT = 3'd3;
	localparam logic [2:0] REG_BAND = 3'd4;
	localparam logic [2:0] REG_TINT_R = 3'd5;
	localparam logic [2:0] REG_TINT_G = 3'd6;
	localparam logic [2:0] REG_TINT_B = 3'd7;

	localparam logic [15:0] RECIP_100 = 16'd41944;
	localparam int RECIP_SHIFT = 22;
	localparam logic [NUM_W-1:0] HUE_60 = NUM_W'(65536 / 6);

	typedef struct packed {
		logic hue;
		logic band;
		logic alpha;
	} item_ctrl_t;

	typedef struct packed {
		item_ctrl_t ctrl;
		logic [LANES-1:0][NUM_W-1:0] num;
		logic [LANES-1:0][DEN_W-1:0] den;
	} div_req_t;

endpackage

// ===== src/gpm_front.sv =====
// Front end: configuration registers, pixel transfer, window test, split point
// and setup of the division requests. Depends on gpm_pkg.
module gpm_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [gpm_pkg::GRAY_W-1:0] gray_level,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [gpm_pkg::DATA_W-1:0] cfg_data,
	output logic push,
	output gpm_pkg::div_req_t req
);
	import gpm_pkg::*;

	logic mode_q;
	logic [7:0] low_q, high_q, band_q, tint_r_q, tint_g_q, tint_b_q;
	logic [6:0] split_q;

	logic valid_s1, inwin_s1;
	logic [7:0] g_s1;
	logic [14:0] prod_s1;
	logic valid_s2, inwin_s2;
	logic [7:0] g_s2;
	logic [SPLIT_W-1:0] t_s2;
	logic [30:0] recip_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			low_q <= 8'd0;
			high_q <= 8'd255;
			split_q <= 7'd50;
			band_q <= 8'd4;
			tint_r_q <= 8'd0;
			tint_g_q <= 8'd0;
			tint_b_q <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE: mode_q <= cfg_data[0];
				REG_LOW: low_q <= cfg_data;
				REG_HIGH: high_q <= cfg_data;
				REG_SPLIT: split_q <= cfg_data[6:0];
				REG_BAND: band_q <= cfg_data;
				REG_TINT_R: tint_r_q <= cfg_data;
				REG_TINT_G: tint_g_q <= cfg_data;
				REG_TINT_B: tint_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	assign recip_prod = {16'b0, prod_s1} * {15'b0, RECIP_100};

	always_ff @(posedge clk) begin
		g_s1 <= gray_level;
		inwin_s1 <= (low_q <= gray_level) && (gray_level <= high_q);
		prod_s1 <= {7'b0, high_q - low_q} * {8'b0, split_q};
		g_s2 <= g_s1;
		inwin_s2 <= inwin_s1;
		t_s2 <= {1'b0, low_q} + recip_prod[RECIP_SHIFT+SPLIT_W-1:RECIP_SHIFT];
	end

	always_comb begin
		logic [SPLIT_W-1:0] g9, d_lo, d_hi;
		logic [10:0] n_lo, n_hi, e;
		logic [DEN_W-1:0] den_lo, den_hi;
		logic [7:0] m;
		logic lower;
		g9 = {1'b0, g_s2};
		lower = g9 < t_s2;
		d_lo = t_s2 - {1'b0, low_q};
		d_hi = {1'b0, high_q} - t_s2;
		n_lo = ({2'b0, d_lo} << 1) + {2'b0, d_lo} + {2'b0, t_s2 - g9};
		n_hi = {3'b0, high_q - g_s2};
		den_lo = {d_lo, 2'b0} + {1'b0, d_lo, 1'b0};
		den_hi = {d_hi, 2'b0} + {1'b0, d_hi, 1'b0};
		e = {3'b0, g_s2} + {4'b0, band_q[7:1]} - {2'b0, t_s2};
		m = tint_r_q;
		if (tint_g_q > m) m = tint_g_q;
		if (tint_b_q > m) m = tint_b_q;
		req.ctrl.alpha = inwin_s2;
		req.ctrl.hue = inwin_s2 && mode_q;
		req.ctrl.band = !e[10] && (e[9:0] < {2'b0, band_q});
		for (int l = 0; l < LANES; l++) begin
			req.num[l] = '0;
			req.den[l] = DEN_W'(1);
		end
		if (inwin_s2) begin
			if (mode_q) begin
				if (lower) begin
					req.num[0] = {n_lo, 16'b0};
					req.den[0] = den_lo;
				end else if (d_hi == '0) begin
					req.num[0] = HUE_60;
				end else begin
					req.num[0] = {n_hi, 16'b0};
					req.den[0] = den_hi;
				end
			end else if (m == 8'd0) begin
				for (int l = 0; l < LANES; l++) req.num[l] = NUM_W'(g_s2);
			end else begin
				req.num[0] = NUM_W'({8'b0, tint_r_q} * {8'b0, g_s2});
				req.num[1] = NUM_W'({8'b0, tint_g_q} * {8'b0, g_s2});
				req.num[2] = NUM_W'({8'b0, tint_b_q} * {8'b0, g_s2});
				for (int l = 0; l < LANES; l++) req.den[l] = {3'b0, m};
			end
		end
	end

	assign push = valid_s2;

endmodule

// ===== src/gpm_queue.sv =====
// Two-entry queue of division requests between the front and back ends.
// Depends on gpm_pkg.
module gpm_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input gpm_pkg::div_req_t push_data,
	input logic pop,
	output logic valid,
	output logic full,
	output gpm_pkg::div_req_t pop_data
);
	import gpm_pkg::*;

	div_req_t entry_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop && valid) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop && valid);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	assign valid = count_q != 2'd0;
	assign full = count_q == 2'd2;
	assign pop_data = entry_q[rd_ptr_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && full |-> pop) else $error("queue transfer into a full queue");

endmodule

// ===== src/gpm_divider.sv =====
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// Carries the item control alongside. Depends on gpm_pkg.
module gpm_divider (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input gpm_pkg::div_req_t req,
	output logic out_valid,
	output gpm_pkg::item_ctrl_t out_ctrl,
	output logic [gpm_pkg::LANES-1:0][gpm_pkg::QUO_W-1:0] quo
);
	import gpm_pkg::*;

	logic [QUO_W-1:0] valid_s;
	item_ctrl_t ctrl_s [QUO_W];
	logic [LANES-1:0][DEN_W-1:0] rem_s [QUO_W];
	logic [LANES-1:0][DEN_W-1:0] den_s [QUO_W];
	logic [LANES-1:0][QUO_W-1:0] low_s [QUO_W];
	logic [LANES-1:0][QUO_W-1:0] quo_s [QUO_W];

	logic [QUO_W-1:0] valid_in;
	item_ctrl_t ctrl_in [QUO_W];
	logic [LANES-1:0][DEN_W-1:0] rem_in [QUO_W];
	logic [LANES-1:0][DEN_W-1:0] den_in [QUO_W];
	logic [LANES-1:0][QUO_W-1:0] low_in [QUO_W];
	logic [LANES-1:0][QUO_W-1:0] quo_in [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		if (k == 0) begin : g_first
			always_comb begin
				valid_in[k] = in_valid;
				ctrl_in[k] = req.ctrl;
				for (int l = 0; l < LANES; l++) begin
					rem_in[k][l] = req.num[l][NUM_W-1:QUO_W];
					low_in[k][l] = req.num[l][QUO_W-1:0];
					den_in[k][l] = req.den[l];
					quo_in[k][l] = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				valid_in[k] = valid_s[k-1];
				ctrl_in[k] = ctrl_s[k-1];
				rem_in[k] = rem_s[k-1];
				low_in[k] = low_s[k-1];
				den_in[k] = den_s[k-1];
				quo_in[k] = quo_s[k-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[k] <= 1'b0;
			else valid_s[k] <= valid_in[k];
		end

		always_ff @(posedge clk) begin
			logic [DEN_W:0] cur;
			logic ge;
			ctrl_s[k] <= ctrl_in[k];
			den_s[k] <= den_in[k];
			for (int l = 0; l < LANES; l++) begin
				cur = {rem_in[k][l], low_in[k][l][QUO_W-1]};
				ge = cur >= {1'b0, den_in[k][l]};
				rem_s[k][l] <= ge ? DEN_W'(cur - {1'b0, den_in[k][l]}) : cur[DEN_W-1:0];
				low_s[k][l] <= {low_in[k][l][QUO_W-2:0], 1'b0};
				quo_s[k][l] <= {quo_in[k][l][QUO_W-2:0], ge};
			end
		end
	end

	assign out_valid = valid_s[QUO_W-1];
	assign out_ctrl = ctrl_s[QUO_W-1];
	assign quo = quo_s[QUO_W-1];

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(in_valid, QUO_W)) else $error("divider result without request");

endmodule

// ===== src/gpm_back.sv =====
// Back end: division pipeline, hue to RGB conversion, dead band and result.
// Depends on gpm_pkg and gpm_divider.
module gpm_back (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input gpm_pkg::div_req_t req,
	output logic done,
	output logic [gpm_pkg::DATA_W-1:0] out_red,
	output logic [gpm_pkg::DATA_W-1:0] out_green,
	output logic [gpm_pkg::DATA_W-1:0] out_blue,
	output logic [gpm_pkg::DATA_W-1:0] out_alpha
);
	import gpm_pkg::*;

	localparam logic [HUE_X_W-1:0] SEC1 = HUE_X_W'(65536);
	localparam logic [HUE_X_W-1:0] SEC2 = HUE_X_W'(131072);
	localparam logic [HUE_X_W-1:0] SEC3 = HUE_X_W'(196608);
	localparam logic [HUE_X_W-1:0] SEC4 = HUE_X_W'(262144);
	localparam logic [HUE_X_W-1:0] SEC5 = HUE_X_W'(327680);
	localparam logic [HUE_X_W-1:0] SEC6 = HUE_X_W'(393216);

	logic div_valid;
	item_ctrl_t div_ctrl;
	logic [LANES-1:0][QUO_W-1:0] quo;

	logic valid_s1;
	item_ctrl_t ctrl_s1;
	logic [HUE_X_W-1:0] x_s1;
	logic [LANES-1:0][DATA_W-1:0] q_s1;
	logic valid_s2;
	logic [DATA_W-1:0] red_s2, green_s2, blue_s2, alpha_s2;

	gpm_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.req(req),
		.out_valid(div_valid),
		.out_ctrl(div_ctrl),
		.quo(quo)
	);

	function automatic logic [DATA_W-1:0] scale255(input logic [16:0] v);
		logic [24:0] p;
		p = {v, 8'b0} - {8'b0, v};
		return p[23:16];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= div_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctrl_s1 <= div_ctrl;
		x_s1 <= {1'b0, quo[0], 2'b0} + {2'b0, quo[0], 1'b0};
		for (int l = 0; l < LANES; l++) q_s1[l] <= quo[l][DATA_W-1:0];
	end

	always_ff @(posedge clk) begin
		logic [HUE_X_W-1:0] ramp;
		logic [DATA_W-1:0] s;
		logic [DATA_W-1:0] r, g, b;
		if (x_s1 <= SEC1) ramp = x_s1;
		else if (x_s1 <= SEC2) ramp = SEC2 - x_s1;
		else if (x_s1 <= SEC3) ramp = x_s1 - SEC2;
		else if (x_s1 <= SEC4) ramp = SEC4 - x_s1;
		else if (x_s1 <= SEC5) ramp = x_s1 - SEC4;
		else ramp = SEC6 - x_s1;
		s = scale255(ramp[16:0]);
		if (x_s1 <= SEC1) begin
			r = 8'd255; g = s; b = 8'd0;
		end else if (x_s1 <= SEC2) begin
			r = s; g = 8'd255; b = 8'd0;
		end else if (x_s1 <= SEC3) begin
			r = 8'd0; g = 8'd255; b = s;
		end else if (x_s1 <= SEC4) begin
			r = 8'd0; g = s; b = 8'd255;
		end else if (x_s1 <= SEC5) begin
			r = s; g = 8'd0; b = 8'd255;
		end else begin
			r = 8'd255; g = 8'd0; b = s;
		end
		if (!ctrl_s1.alpha) begin
			red_s2 <= '0; green_s2 <= '0; blue_s2 <= '0; alpha_s2 <= '0;
		end else if (ctrl_s1.hue) begin
			red_s2 <= ctrl_s1.band ? '0 : r;
			green_s2 <= ctrl_s1.band ? '0 : g;
			blue_s2 <= ctrl_s1.band ? '0 : b;
			alpha_s2 <= 8'd255;
		end else begin
			red_s2 <= q_s1[0];
			green_s2 <= q_s1[1];
			blue_s2 <= q_s1[2];
			alpha_s2 <= 8'd255;
		end
	end

	assign done = valid_s2;
	assign out_red = red_s2;
	assign out_green = green_s2;
	assign out_blue = blue_s2;
	assign out_alpha = alpha_s2;

	a_outside_black: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_alpha == 8'd0 |-> out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
		else $error("colored result outside the window");

endmodule

// ===== src/gray_to_pseudocolor_mapper_unit.sv =====
// Top level of the gray to pseudocolor mapper.
// Depends on gpm_pkg, gpm_front, gpm_queue and gpm_back.
//
// Channel   Signals                                   Transfer
// pixel     start, busy, gray_level                   start && !busy
// config    cfg_we, cfg_index, cfg_data               cfg_we
// result    done, out_red, out_green, out_blue,       done, one cycle
//           out_alpha
//
// One pixel is taken every cycle; its result is transferred once the pixel has passed
// two front stages, one queue stage, the 16-stage divider pipeline and two color stages.
// Reset clears the pipeline valid bits, the queue and loads the register defaults.
// The receiver cannot stall; the queue drains every cycle, so busy stays low.
module gray_to_pseudocolor_mapper_unit (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [gpm_pkg::GRAY_W-1:0] gray_level,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [gpm_pkg::DATA_W-1:0] cfg_data,
	output logic done,
	output logic [gpm_pkg::DATA_W-1:0] out_red,
	output logic [gpm_pkg::DATA_W-1:0] out_green,
	output logic [gpm_pkg::DATA_W-1:0] out_blue,
	output logic [gpm_pkg::DATA_W-1:0] out_alpha
);
	import gpm_pkg::*;

	logic push, q_valid, q_full;
	div_req_t push_req, pop_req;

	gpm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.gray_level(gray_level),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.req(push_req)
	);

	gpm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_req),
		.pop(q_valid),
		.valid(q_valid),
		.full(q_full),
		.pop_data(pop_req)
	);

	gpm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(q_valid),
		.req(pop_req),
		.done(done),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.out_alpha(out_alpha)
	);

	assign busy = q_full;

endmodule
